>>> src/mt_rng_pkg.sv
// Shared types and constants for the MT19937 random generator.
package mt_rng_pkg;

    localparam int C_TABLE_DEPTH   = 624;
    localparam int C_MIDDLE_OFFSET = 397;

    localparam logic [31:0] C_SEED_MULT = 32'd1812433253;
    localparam logic [31:0] C_TWIST_XOR = 32'h9908_b0df;
    localparam logic [31:0] C_TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] C_TEMPER_C  = 32'hefc6_0000;
    localparam logic [31:0] C_TOP_BIT   = 32'h8000_0000;
    localparam logic [31:0] C_LOW_BITS  = 32'h7fff_ffff;

    typedef struct packed {
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } t_in;

    typedef struct packed {
        logic        [31:0] raw_word;
        logic signed [31:0] ranged_value;
    } t_out;

    typedef struct packed {
        logic fill_start;
        logic fill_step;
        logic draw_read;
        logic twist;
        logic mul;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
    } t_stat;

endpackage

>>> src/mt19937_random_generator.sv
// Top level of the MT19937 random generator with ranged draw.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in  (low_bound, high_bound)
//  out     | output    | o_out_valid / i_out_ready  | o_out (raw_word, ranged_value)
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_data (seed)
//
// A beat passes through IDLE, TWIST, MUL and FIN: accepting it reads two table words,
// TWIST does twist-and-temper, MUL the 32x32 multiply, and FIN the scale-and-add,
// which loads the result once the output is free; only then is the next beat taken.
// After reset and after every seed write the table refills one entry per cycle
// through the seed multiplier, with o_in_ready low until the fill ends.
// A held result does not block the next input beat; only the final load waits for it.
module mt19937_random_generator #(
    parameter int TABLE_DEPTH   = mt_rng_pkg::C_TABLE_DEPTH,
    parameter int MIDDLE_OFFSET = mt_rng_pkg::C_MIDDLE_OFFSET
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [31:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mt_rng_pkg::t_in    i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mt_rng_pkg::t_out   o_out
);
    import mt_rng_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence fill, draw and output load.
    mt_rng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold the state table; twist one entry per draw, temper, scale into range.
    mt_rng_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MIDDLE_OFFSET (MIDDLE_OFFSET)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

endmodule

>>> src/mt_rng_ctrl.sv
// Controller state machine of the MT19937 random generator.
module mt_rng_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mt_rng_pkg::t_stat  i_stat,
    output mt_rng_pkg::t_cmd   o_cmd
);
    import mt_rng_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_IDLE  = 3'd2;
    localparam logic [2:0] S_TWIST = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_INIT: begin
                cmd.fill_start = 1'b1;
                n_state        = S_FILL;
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.draw_read = 1'b1;
                    n_state       = S_TWIST;
                end
            end
            S_TWIST: begin
                cmd.twist = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        // A seed write restarts the table fill from any state.
        if (i_cfg_we) begin
            cmd            = '0;
            cmd.fill_start = 1'b1;
            n_state        = S_FILL;
        end
    end

    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTH
    a_accept_twists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_TWIST))
        else $error("accepted beat did not enter the twist step");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("input taken while the table refills");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (!r_out_valid || i_out_ready) && !i_cfg_we)
        |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished result not presented");
`endif

endmodule

>>> src/mt_rng_datapath.sv
// Datapath of the MT19937 random generator: state table, twist, temper and range scaling.
module mt_rng_datapath #(
    parameter int TABLE_DEPTH   = mt_rng_pkg::C_TABLE_DEPTH,
    parameter int MIDDLE_OFFSET = mt_rng_pkg::C_MIDDLE_OFFSET
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic signed [31:0] i_cfg_data,
    input  mt_rng_pkg::t_in    i_in,
    output mt_rng_pkg::t_out   o_out,
    input  mt_rng_pkg::t_cmd   i_cmd,
    output mt_rng_pkg::t_stat  o_stat
);
    import mt_rng_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic [31:0] mem [TABLE_DEPTH];

    logic [31:0]   r_seed;
    logic [IW-1:0] r_fill_idx;
    logic [31:0]   r_prev;
    logic [IW-1:0] r_pos;
    logic [31:0]   r_cur;
    logic [31:0]   r_rd_nxt;
    logic [31:0]   r_rd_mid;
    logic [31:0]   r_lo;
    logic [31:0]   r_hi;
    logic [31:0]   r_word;
    logic [32:0]   r_mag;
    logic          r_neg;
    logic [63:0]   r_prod;
    t_out          r_out;

    logic [31:0]   fold;
    logic [31:0]   fill_mul;
    logic [31:0]   fill_val;
    logic [IW-1:0] pos_nxt;
    logic [IW:0]   mid_sum;
    logic [IW-1:0] pos_mid;
    logic [31:0]   y;
    logic [31:0]   twist_val;
    logic [31:0]   t1, t2, t3, t4;
    logic [32:0]   range33;
    logic [32:0]   mag33;
    logic [31:0]   q;
    logic [31:0]   q_signed;
    logic          we;
    logic [IW-1:0] waddr;
    logic [31:0]   wdata;

    // Seed recurrence: one entry per cycle.
    always_comb begin
        fold     = r_prev ^ (r_prev >> 30);
        fill_mul = C_SEED_MULT * fold;
        if (r_fill_idx == '0) begin
            fill_val = r_seed;
        end else begin
            fill_val = fill_mul + {{(32 - IW){1'b0}}, r_fill_idx};
        end
    end

    // Neighbor and middle addresses of the current position.
    always_comb begin
        pos_nxt = (r_pos == IW'(TABLE_DEPTH - 1)) ? '0 : r_pos + 1'b1;
        mid_sum = {1'b0, r_pos} + (IW + 1)'(MIDDLE_OFFSET);
        if (mid_sum >= (IW + 1)'(TABLE_DEPTH)) begin
            pos_mid = IW'(mid_sum - (IW + 1)'(TABLE_DEPTH));
        end else begin
            pos_mid = mid_sum[IW-1:0];
        end
    end

    // Twist one entry lazily, then temper it.
    always_comb begin
        y         = (r_cur & C_TOP_BIT) | (r_rd_nxt & C_LOW_BITS);
        twist_val = r_rd_mid ^ (y >> 1) ^ (y[0] ? C_TWIST_XOR : 32'd0);
        t1        = twist_val ^ (twist_val >> 11);
        t2        = t1 ^ ((t1 << 7) & C_TEMPER_B);
        t3        = t2 ^ ((t2 << 15) & C_TEMPER_C);
        t4        = t3 ^ (t3 >> 18);
        range33   = {r_hi[31], r_hi} - {r_lo[31], r_lo};
        mag33     = range33[32] ? (~range33 + 33'd1) : range33;
    end

    always_comb begin
        q        = r_prod[63:32] + (r_mag[32] ? r_word : 32'd0);
        q_signed = r_neg ? (32'd0 - q) : q;
    end

    always_comb begin
        we    = i_cmd.fill_step || i_cmd.twist;
        waddr = i_cmd.fill_step ? r_fill_idx : r_pos;
        wdata = i_cmd.fill_step ? fill_val : twist_val;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.draw_read) begin
            r_rd_nxt <= mem[pos_nxt];
            r_rd_mid <= mem[pos_mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_fill_idx <= '0;
            r_pos      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            if (i_cmd.fill_start) begin
                r_fill_idx <= '0;
                r_pos      <= '0;
            end else if (i_cmd.fill_step) begin
                r_fill_idx <= (r_fill_idx == IW'(TABLE_DEPTH - 1)) ? '0 : r_fill_idx + 1'b1;
            end else if (i_cmd.twist) begin
                r_pos <= pos_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_step) begin
            r_prev <= fill_val;
            if (r_fill_idx == '0) begin
                r_cur <= fill_val;
            end
        end
        if (i_cmd.draw_read) begin
            r_lo <= i_in.low_bound;
            r_hi <= i_in.high_bound;
        end
        if (i_cmd.twist) begin
            r_cur  <= r_rd_nxt;
            r_word <= t4;
            r_mag  <= mag33;
            r_neg  <= range33[32];
        end
        if (i_cmd.mul) begin
            r_prod <= r_word * r_mag[31:0];
        end
        if (i_cmd.load_out) begin
            r_out.raw_word     <= r_word;
            r_out.ranged_value <= q_signed + r_lo;
        end
    end

    assign o_out            = r_out;
    assign o_stat.fill_last = (r_fill_idx == IW'(TABLE_DEPTH - 1));

`ifndef SYNTH
    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < IW'(TABLE_DEPTH))
        else $error("table position left the table");

    a_fill_restarts_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_start |=> ((r_pos == '0) && (r_fill_idx == '0)))
        else $error("fill did not restart at entry zero");
`endif

endmodule
